/* rtl/core/bta_pkg.sv */
// Shared types and constants for the boundary-tag allocator core.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bta_pkg;

    localparam int ADDR_W    = 10;
    localparam int SIZE_W    = 11;
    localparam int SLACK_W   = 10;
    localparam int WORD_W    = 32;
    localparam int MAX_STORE = 1024;

    localparam logic CFG_TOTAL = 1'b0;
    localparam logic CFG_SLACK = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_NOP   = 2'd3
    } t_opcode;

    typedef enum logic [5:0] {
        S_IDLE, S_INIT_H, S_INIT_F,
        S_A_BEGIN, S_A_RD, S_A_CHK, S_A_TAKE, S_A_EMPTY,
        S_A_RD_NXT, S_A_WR_NXT, S_A_RD_PR, S_A_WR_PR,
        S_A_RD_P, S_A_WR_TP, S_A_RD_F, S_A_WR_TF,
        S_A_WR_SZ, S_A_WR_NF, S_A_WR_H, S_A_WR_F, S_A_FAIL,
        S_F_BEGIN, S_F_RD_P, S_F_CHK, S_F_RD_L, S_F_LCHK, S_F_RD_R, S_F_RCHK,
        S_F_BRANCH, S_F_RD_S, S_F_WR_S, S_F_WR_PF,
        S_F_RD_Q, S_F_WR_Q, S_F_RD_Q1, S_F_WR_Q1, S_F_R_SELF, S_F_WR_PH,
        S_F_RD_TF, S_F_WR_TF, S_F_WR_SOLO,
        S_F_RD_ROV, S_F_WR_PLINK, S_F_RD_ROV2, S_F_WR_ROVLL,
        S_DONE
    } t_step;

    typedef struct packed {
        t_step step;
        logic  accept;
    } t_cmd;

    typedef struct packed {
        t_opcode op;
        logic    a_cont;
        logic    a_fit;
        logic    a_whole;
        logic    a_single;
        logic    empty;
        logic    f_oor;
        logic    f_bad;
        logic    p_zero;
        logic    t_in;
        logic    left;
        logic    right;
        logic    q1_is_t;
        logic    out_free;
    } t_stat;

endpackage

/* rtl/core/bta_ctrl.sv */
// Sequencing controller of the allocator: one step of an operation per state.
// Depends on bta_pkg; drives the datapath through t_cmd and reads t_stat.
`timescale 1ns / 1ps

module bta_ctrl import bta_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_step r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd.step   = r_state;
        o_cmd.accept = (r_state == S_IDLE) && i_in_valid;
        o_in_stall   = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DONE;
                end
            end
            S_INIT_H:   n_state = S_INIT_F;
            S_INIT_F:   n_state = S_DONE;
            S_A_BEGIN:  n_state = i_stat.empty ? S_A_FAIL : S_A_RD;
            S_A_RD:     n_state = S_A_CHK;
            S_A_CHK: begin
                if (i_stat.a_cont) begin
                    n_state = S_A_RD;
                end else if (!i_stat.a_fit) begin
                    n_state = S_A_FAIL;
                end else begin
                    n_state = S_A_TAKE;
                end
            end
            S_A_TAKE: begin
                if (!i_stat.a_whole) begin
                    n_state = S_A_RD_P;
                end else if (i_stat.a_single) begin
                    n_state = S_A_EMPTY;
                end else begin
                    n_state = S_A_RD_NXT;
                end
            end
            S_A_EMPTY:  n_state = S_A_RD_P;
            S_A_RD_NXT: n_state = S_A_WR_NXT;
            S_A_WR_NXT: n_state = S_A_RD_PR;
            S_A_RD_PR:  n_state = S_A_WR_PR;
            S_A_WR_PR:  n_state = S_A_RD_P;
            S_A_RD_P:   n_state = i_stat.a_whole ? S_A_WR_TP : S_A_WR_SZ;
            S_A_WR_TP:  n_state = S_A_RD_F;
            S_A_RD_F:   n_state = S_A_WR_TF;
            S_A_WR_TF:  n_state = S_DONE;
            S_A_WR_SZ:  n_state = S_A_WR_NF;
            S_A_WR_NF:  n_state = S_A_WR_H;
            S_A_WR_H:   n_state = S_A_WR_F;
            S_A_WR_F:   n_state = S_DONE;
            S_A_FAIL:   n_state = S_DONE;
            S_F_BEGIN:  n_state = i_stat.f_oor ? S_DONE : S_F_RD_P;
            S_F_RD_P:   n_state = S_F_CHK;
            S_F_CHK: begin
                if (i_stat.f_bad) begin
                    n_state = S_DONE;
                end else if (!i_stat.p_zero) begin
                    n_state = S_F_RD_L;
                end else begin
                    n_state = i_stat.t_in ? S_F_RD_R : S_F_BRANCH;
                end
            end
            S_F_RD_L:   n_state = S_F_LCHK;
            S_F_LCHK:   n_state = i_stat.t_in ? S_F_RD_R : S_F_BRANCH;
            S_F_RD_R:   n_state = S_F_RCHK;
            S_F_RCHK:   n_state = S_F_BRANCH;
            S_F_BRANCH: begin
                if (i_stat.left) begin
                    n_state = S_F_RD_S;
                end else if (i_stat.right) begin
                    n_state = i_stat.q1_is_t ? S_F_R_SELF : S_F_RD_Q;
                end else begin
                    n_state = S_F_WR_PF;
                end
            end
            S_F_RD_S:   n_state = S_F_WR_S;
            S_F_WR_S:   n_state = i_stat.right ? S_F_RD_Q : S_F_WR_PF;
            S_F_WR_PF: begin
                if (i_stat.left) begin
                    n_state = S_DONE;
                end else begin
                    n_state = i_stat.empty ? S_F_WR_SOLO : S_F_RD_ROV;
                end
            end
            S_F_RD_Q:   n_state = S_F_WR_Q;
            S_F_WR_Q: begin
                n_state = (!i_stat.left && !i_stat.right) ? S_F_RD_ROV2 : S_F_RD_Q1;
            end
            S_F_RD_Q1:  n_state = S_F_WR_Q1;
            S_F_WR_Q1:  n_state = i_stat.left ? S_F_RD_TF : S_F_WR_PH;
            S_F_R_SELF: n_state = S_F_WR_PH;
            S_F_WR_PH:  n_state = S_F_RD_TF;
            S_F_RD_TF:  n_state = S_F_WR_TF;
            S_F_WR_TF:  n_state = S_DONE;
            S_F_WR_SOLO: n_state = S_DONE;
            S_F_RD_ROV: n_state = S_F_WR_PLINK;
            S_F_WR_PLINK: n_state = S_F_RD_Q;
            S_F_RD_ROV2: n_state = S_F_WR_ROVLL;
            S_F_WR_ROVLL: n_state = S_DONE;
            S_DONE:     n_state = i_stat.out_free ? S_IDLE : S_DONE;
            default:    n_state = S_IDLE;
        endcase
        // The operation is chosen from the opcode of the transfer itself.
        if (r_state == S_IDLE && i_in_valid) begin
            unique case (t_opcode'(i_stat.op))
                OP_INIT:  n_state = S_INIT_H;
                OP_ALLOC: n_state = S_A_BEGIN;
                OP_FREE:  n_state = S_F_BEGIN;
                OP_NOP:   n_state = S_DONE;
                default:  n_state = S_DONE;
            endcase
        end
    end

    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && i_stat.out_free) |=> (r_state == S_IDLE))
        else $error("controller left the done state wrongly");

    a_walk_checks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_CHK) |-> ($past(r_state) == S_A_RD))
        else $error("list walk check without a preceding read");

    a_empty_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_A_BEGIN && i_stat.empty) |=> (r_state == S_A_FAIL))
        else $error("allocate on an empty list did not fail");

endmodule

/* rtl/core/bta_dpath.sv */
// Datapath of the allocator: word store, operation registers, free-list state,
// configuration registers and the result register. Depends on bta_pkg.
`timescale 1ns / 1ps

module bta_dpath import bta_pkg::*; #(
    parameter int MEM_WORDS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_cmd,
    output t_stat              o_stat,
    input  logic [1:0]         i_opcode,
    input  logic [SIZE_W-1:0]  i_request_words,
    input  logic [ADDR_W-1:0]  i_block_address,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_result_address,
    output logic               o_status
);

    localparam int STORE = (MEM_WORDS < MAX_STORE) ? MEM_WORDS : MAX_STORE;
    localparam int IDX_W = $clog2(STORE);
    localparam logic [SIZE_W-1:0] STORE_SZ = SIZE_W'(STORE);

    logic [WORD_W-1:0] r_mem [STORE];
    logic [WORD_W-1:0] r_rdata;
    logic              r_rd_ok;

    t_opcode           r_op;
    logic [SIZE_W-1:0] r_req, r_sz, r_t, r_tsz, r_steps, r_region, r_total;
    logic [ADDR_W-1:0] r_p, r_nxt, r_pr, r_s, r_q, r_q1, r_rover;
    logic [SLACK_W-1:0] r_slack;
    logic              r_empty, r_left, r_right;
    logic [ADDR_W-1:0] r_res;
    logic              r_status;
    logic              r_out_valid;
    logic [ADDR_W-1:0] r_out_addr;
    logic              r_out_status;

    logic [WORD_W-1:0] rdata;
    logic              rd_tag;
    logic [SIZE_W-1:0] rd_size;
    logic [ADDR_W-1:0] rd_rl, rd_ll;
    logic [SLACK_W-1:0] slack_eff;
    logic [SIZE_W-1:0] leftover, f_addr, nf_addr, h_addr, tf_addr, t_init, sz_sum, n_req;
    logic [SIZE_W:0]   p_end;
    logic [SIZE_W-1:0] t_cur;
    logic [ADDR_W-1:0] link_new;
    logic              out_free;

    logic [SIZE_W-1:0] mem_addr;
    logic              mem_re, mem_we, mem_ok;
    logic [WORD_W-1:0] mem_wdata;

    function automatic logic [WORD_W-1:0] make_word(input logic tag,
            input logic [SIZE_W-1:0] size, input logic [ADDR_W-1:0] rl,
            input logic [ADDR_W-1:0] ll);
        return {tag, size, rl, ll};
    endfunction

    assign rdata   = r_rd_ok ? r_rdata : '0;
    assign rd_tag  = rdata[31];
    assign rd_size = rdata[30:20];
    assign rd_rl   = rdata[19:10];
    assign rd_ll   = rdata[9:0];

    assign slack_eff = (r_slack == '0) ? SLACK_W'(1) : r_slack;
    assign leftover  = r_sz - r_req;
    assign f_addr    = {1'b0, r_p} + r_sz - SIZE_W'(1);
    assign nf_addr   = {1'b0, r_p} + leftover - SIZE_W'(1);
    assign h_addr    = {1'b0, r_p} + leftover;
    assign tf_addr   = r_t + r_tsz - SIZE_W'(1);
    assign sz_sum    = rd_size + r_sz + (r_right ? r_tsz : '0);
    assign p_end     = {2'b00, r_p} + {1'b0, rd_size};
    assign link_new  = r_left ? r_s : r_p;
    assign out_free  = !r_out_valid || !i_out_stall;
    assign n_req     = (i_request_words < SIZE_W'(2)) ? SIZE_W'(2) : i_request_words;
    // The block end is registered during the head check, so that step looks at it directly.
    assign t_cur     = (i_cmd.step == S_F_CHK) ? p_end[SIZE_W-1:0] : r_t;

    always_comb begin
        if (r_total > STORE_SZ) begin
            t_init = STORE_SZ;
        end else if (r_total < SIZE_W'(2)) begin
            t_init = SIZE_W'(2);
        end else begin
            t_init = r_total;
        end
    end

    // Memory port: at most one read or one write per step.
    always_comb begin
        mem_addr  = '0;
        mem_re    = 1'b0;
        mem_we    = 1'b0;
        mem_wdata = '0;
        unique case (i_cmd.step)
            S_INIT_H: begin
                mem_we = 1'b1; mem_wdata = make_word(1'b0, t_init, '0, '0);
            end
            S_INIT_F: begin
                mem_we = 1'b1; mem_addr = r_t - SIZE_W'(1);
            end
            S_A_RD, S_A_RD_P, S_F_RD_P: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_p};
            end
            S_A_RD_NXT: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_nxt};
            end
            S_A_WR_NXT: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_nxt};
                mem_wdata = {rdata[31:10], r_pr};
            end
            S_A_RD_PR: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_pr};
            end
            S_A_WR_PR: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_pr};
                mem_wdata = {rdata[31:20], r_nxt, rdata[9:0]};
            end
            S_A_WR_TP: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_p}; mem_wdata = {1'b1, rdata[30:0]};
            end
            S_A_RD_F: begin
                mem_re = 1'b1; mem_addr = f_addr;
            end
            S_A_WR_TF: begin
                mem_we = 1'b1; mem_addr = f_addr; mem_wdata = {1'b1, rdata[30:0]};
            end
            S_A_WR_SZ: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_p};
                mem_wdata = {rdata[31], leftover, rdata[19:0]};
            end
            S_A_WR_NF: begin
                mem_we = 1'b1; mem_addr = nf_addr;
                mem_wdata = make_word(1'b0, '0, '0, r_p);
            end
            S_A_WR_H: begin
                mem_we = 1'b1; mem_addr = h_addr;
                mem_wdata = make_word(1'b1, r_req, '0, '0);
            end
            S_A_WR_F: begin
                mem_we = 1'b1; mem_addr = f_addr;
                mem_wdata = make_word(1'b1, '0, '0, h_addr[ADDR_W-1:0]);
            end
            S_F_RD_L: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_p} - SIZE_W'(1);
            end
            S_F_RD_R: begin
                mem_re = 1'b1; mem_addr = r_t;
            end
            S_F_RD_S: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_s};
            end
            S_F_WR_S: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_s};
                mem_wdata = {rdata[31], sz_sum, rdata[19:0]};
            end
            S_F_WR_PF: begin
                mem_we = 1'b1; mem_addr = f_addr;
                mem_wdata = make_word(1'b0, '0, '0, link_new);
            end
            S_F_RD_Q: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_q};
            end
            S_F_WR_Q: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_q};
                mem_wdata = {rdata[31:20], (r_left ? r_q1 : r_p), rdata[9:0]};
            end
            S_F_RD_Q1: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_q1};
            end
            S_F_WR_Q1: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_q1};
                mem_wdata = {rdata[31:10], (r_left ? r_q : r_p)};
            end
            S_F_WR_PH: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_p};
                mem_wdata = make_word(1'b0, r_sz + r_tsz, r_q1, r_q);
            end
            S_F_RD_TF: begin
                mem_re = 1'b1; mem_addr = tf_addr;
            end
            S_F_WR_TF: begin
                mem_we = 1'b1; mem_addr = tf_addr;
                mem_wdata = {rdata[31:10], link_new};
            end
            S_F_WR_SOLO: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_p};
                mem_wdata = make_word(1'b0, r_sz, r_p, r_p);
            end
            S_F_RD_ROV, S_F_RD_ROV2: begin
                mem_re = 1'b1; mem_addr = {1'b0, r_rover};
            end
            S_F_WR_PLINK: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_p};
                mem_wdata = make_word(1'b0, r_sz, r_rover, rd_ll);
            end
            S_F_WR_ROVLL: begin
                mem_we = 1'b1; mem_addr = {1'b0, r_rover};
                mem_wdata = {rdata[31:10], r_p};
            end
            default: begin
                mem_re = 1'b0;
            end
        endcase
    end

    // Addresses past the store read as zero and drop writes.
    assign mem_ok = (mem_addr < STORE_SZ);

    always_ff @(posedge i_clk) begin
        if (mem_we && mem_ok) begin
            r_mem[mem_addr[IDX_W-1:0]] <= mem_wdata;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_addr[IDX_W-1:0]];
            r_rd_ok <= mem_ok;
        end
    end

    // Control state of the free list and the configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover     <= '0;
            r_empty     <= 1'b1;
            r_region    <= '0;
            r_total     <= SIZE_W'(1024);
            r_slack     <= SLACK_W'(8);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TOTAL) begin
                    r_total <= i_cfg_data;
                end else begin
                    r_slack <= i_cfg_data[SLACK_W-1:0];
                end
            end
            // A waiting result stays until its transfer; the done step loads a new one.
            r_out_valid <= (r_out_valid && i_out_stall) || (i_cmd.step == S_DONE && out_free);
            unique case (i_cmd.step)
                S_INIT_F: begin
                    r_rover <= '0; r_empty <= 1'b0; r_region <= r_t;
                end
                S_A_TAKE:     r_rover <= r_nxt;
                S_A_EMPTY: begin
                    r_empty <= 1'b1; r_rover <= '0;
                end
                S_F_WR_TF: begin
                    if ({1'b0, r_rover} == r_t) begin
                        r_rover <= link_new;
                    end
                end
                S_F_WR_SOLO: begin
                    r_empty <= 1'b0; r_rover <= r_p;
                end
                S_F_WR_ROVLL: r_rover <= r_p;
                default: begin
                    r_rover <= r_rover;
                end
            endcase
        end
    end

    // Operation registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_req    <= n_req;
            r_p      <= i_block_address;
            r_res    <= '0;
            r_status <= 1'b0;
        end
        unique case (i_cmd.step)
            S_INIT_H:  r_t <= t_init;
            S_A_BEGIN: begin
                r_p <= r_rover; r_steps <= '0;
            end
            S_A_CHK: begin
                r_sz <= rd_size; r_nxt <= rd_rl; r_pr <= rd_ll;
                if (o_stat.a_cont) begin
                    r_p     <= rd_rl;
                    r_steps <= r_steps + SIZE_W'(1);
                end
            end
            S_A_WR_TF: r_res <= r_p;
            S_A_WR_F:  r_res <= h_addr[ADDR_W-1:0];
            S_A_FAIL: begin
                r_res <= '0; r_status <= 1'b1;
            end
            S_F_CHK: begin
                r_sz <= rd_size; r_t <= p_end[SIZE_W-1:0];
                r_left <= 1'b0; r_right <= 1'b0;
            end
            S_F_LCHK: begin
                r_left <= !rd_tag; r_s <= rd_ll;
            end
            S_F_RCHK: begin
                r_right <= !rd_tag; r_tsz <= rd_size; r_q <= rd_ll; r_q1 <= rd_rl;
            end
            S_F_R_SELF: begin
                r_q <= r_p; r_q1 <= r_p;
            end
            S_F_WR_PLINK: r_q <= rd_ll;
            S_DONE: begin
                if (out_free) begin
                    r_out_addr   <= r_res;
                    r_out_status <= r_status;
                end
            end
            default: begin
                r_steps <= r_steps;
            end
        endcase
    end

    always_comb begin
        o_stat.op       = i_cmd.accept ? t_opcode'(i_opcode) : r_op;
        o_stat.a_cont   = (rd_size < r_req) && (rd_rl != r_rover) && (r_steps < STORE_SZ);
        o_stat.a_fit    = (rd_size >= r_req);
        o_stat.a_whole  = (leftover <= {1'b0, slack_eff});
        o_stat.a_single = (r_nxt == r_p);
        o_stat.empty    = r_empty;
        o_stat.f_oor    = ({1'b0, r_p} >= r_region);
        o_stat.f_bad    = !rd_tag || (rd_size < SIZE_W'(2)) || (p_end > {1'b0, r_region});
        o_stat.p_zero   = (r_p == '0);
        o_stat.t_in     = (t_cur < r_region);
        o_stat.left     = r_left;
        o_stat.right    = r_right;
        o_stat.q1_is_t  = ({1'b0, r_q1} == r_t);
        o_stat.out_free = out_free;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_out_addr;
    assign o_status         = r_out_status;

    a_push_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(i_cmd.step) == S_DONE))
        else $error("result pushed outside the done step");

    a_init_fills_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == S_INIT_F) |=> (!r_empty && r_rover == '0))
        else $error("init did not leave one free block at the rover");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == S_IDLE || i_cmd.step == S_DONE) |-> !mem_we)
        else $error("store written while no operation runs");

endmodule

/* rtl/core/boundary_tag_allocator_core.sv */
// Boundary-tag first-fit allocator. Every transfer gives one result.
// Init writes the head and foot of one free block; free checks both neighbours and
// rewrites sizes and links by read-modify-writes on the single store port; allocate
// walks the free list, then unlinks or splits the block it takes, or fails on an empty list.
// One operation runs at a time; the next transfer is taken once the result is registered.
// Reset empties the free list and clears control state; the store is not cleared.
`timescale 1ns / 1ps

module boundary_tag_allocator_core import bta_pkg::*; #(
    parameter int MEM_WORDS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_opcode,
    input  logic [SIZE_W-1:0]  i_request_words,
    input  logic [ADDR_W-1:0]  i_block_address,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [SIZE_W-1:0]  i_cfg_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [ADDR_W-1:0]  o_result_address,
    output logic               o_status
);

    t_cmd  cmd;
    t_stat stat;

    bta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bta_dpath #(.MEM_WORDS(MEM_WORDS)) u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .i_opcode         (i_opcode),
        .i_request_words  (i_request_words),
        .i_block_address  (i_block_address),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_result_address (o_result_address),
        .o_status         (o_status)
    );

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the boundary-tag allocator core.
// Depends on bta_pkg and boundary_tag_allocator_core; it carries its own copy of the allocator.
`timescale 1ns / 1ps

module testbench;
    import bta_pkg::*;

    localparam int STORE     = 1024;
    localparam int STALL_MAX = 50000;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [1:0]         i_opcode = OP_NOP;
    logic [SIZE_W-1:0]  i_request_words = '0;
    logic [ADDR_W-1:0]  i_block_address = '0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_index = CFG_TOTAL;
    logic [SIZE_W-1:0]  i_cfg_data = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [ADDR_W-1:0]  o_result_address;
    logic               o_status;

    boundary_tag_allocator_core i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow copy of the allocator state.
    logic [WORD_W-1:0] heap_mem [STORE];
    bit                heap_written [STORE];
    int unsigned       rover_at, region_size, total_cfg, slack_cfg;
    bit                free_list_empty;

    // Items waiting for the driver and results still owed by the block.
    t_opcode           op_q [$];
    logic [SIZE_W-1:0] req_q [$];
    logic [ADDR_W-1:0] addr_q [$];
    logic [ADDR_W-1:0] want_addr_q [$];
    logic              want_status_q [$];
    int unsigned       live_blocks [$];

    int  errors = 0;
    bit  quiet = 1'b0;
    int  hold_request = 0;
    int  hold_left = 0;
    int  idle_cycles = 0;

    function automatic logic [31:0] rd_word(int unsigned a);
        return (a < STORE) ? heap_mem[a] : 32'd0;
    endfunction

    function automatic void wr_word(int unsigned a, logic [31:0] v);
        if (a < STORE) begin
            heap_mem[a] = v;
            heap_written[a] = 1'b1;
        end
    endfunction

    function automatic logic [31:0] pack_word(int unsigned tg, int unsigned sz,
                                              int unsigned rl, int unsigned ll);
        logic [31:0] w;
        w = {tg[0], sz[10:0], rl[9:0], ll[9:0]};
        return w;
    endfunction

    function automatic int unsigned tag_at(int unsigned a);
        return rd_word(a) >> 31;
    endfunction
    function automatic int unsigned size_at(int unsigned a);
        return (rd_word(a) >> 20) & 32'h7FF;
    endfunction
    function automatic int unsigned fwd_at(int unsigned a);
        return (rd_word(a) >> 10) & 32'h3FF;
    endfunction
    function automatic int unsigned back_at(int unsigned a);
        return rd_word(a) & 32'h3FF;
    endfunction

    function automatic void put_tag(int unsigned a, int unsigned t);
        logic [31:0] w;
        w = rd_word(a);
        w[31] = t[0];
        wr_word(a, w);
    endfunction
    function automatic void put_size(int unsigned a, int unsigned s);
        logic [31:0] w;
        w = rd_word(a);
        w[30:20] = s[10:0];
        wr_word(a, w);
    endfunction
    function automatic void put_fwd(int unsigned a, int unsigned l);
        logic [31:0] w;
        w = rd_word(a);
        w[19:10] = l[9:0];
        wr_word(a, w);
    endfunction
    function automatic void put_back(int unsigned a, int unsigned l);
        logic [31:0] w;
        w = rd_word(a);
        w[9:0] = l[9:0];
        wr_word(a, w);
    endfunction

    function automatic bit alloc_model(int unsigned need, output int unsigned head);
        int unsigned p, sz, foot, nxt, slk, steps, pr, nf;
        head = 0;
        steps = 0;
        if (need < 2) need = 2;
        if (free_list_empty) return 1'b0;
        p = rover_at;
        while (size_at(p) < need && fwd_at(p) != rover_at && steps < STORE) begin
            p = fwd_at(p);
            steps++;
        end
        sz = size_at(p);
        if (sz < need) return 1'b0;
        foot = p + sz - 1;
        nxt = fwd_at(p);
        rover_at = nxt;
        slk = (slack_cfg < 1) ? 1 : slack_cfg;
        if (sz - need <= slk) begin
            if (nxt == p) begin
                free_list_empty = 1'b1;
                rover_at = 0;
            end else begin
                pr = back_at(p);
                put_back(nxt, pr);
                put_fwd(pr, nxt);
            end
            put_tag(p, 1);
            put_tag(foot, 1);
            head = p;
        end else begin
            nf = p + (sz - need) - 1;
            put_size(p, sz - need);
            wr_word(nf, pack_word(0, 0, 0, p));
            wr_word(nf + 1, pack_word(1, need, 0, 0));
            wr_word(foot, pack_word(1, 0, 0, nf + 1));
            head = nf + 1;
        end
        return 1'b1;
    endfunction

    function automatic void free_model(int unsigned p);
        int unsigned sz, t, s, tsz, q, q1;
        bit lf, rt;
        if (p >= region_size || tag_at(p) == 0) return;
        sz = size_at(p);
        if (sz < 2 || p + sz > region_size) return;
        t = p + sz;
        lf = (p > 0 && tag_at(p - 1) == 0);
        rt = (t < region_size && tag_at(t) == 0);
        if (lf && rt) begin
            s = back_at(p - 1);
            tsz = size_at(t);
            q = back_at(t);
            q1 = fwd_at(t);
            put_size(s, size_at(s) + sz + tsz);
            put_fwd(q, q1);
            put_back(q1, q);
            put_back(t + tsz - 1, s);
            if (rover_at == t) rover_at = s;
        end else if (lf) begin
            s = back_at(p - 1);
            put_size(s, size_at(s) + sz);
            wr_word(p + sz - 1, pack_word(0, 0, 0, s));
        end else if (rt) begin
            tsz = size_at(t);
            q = back_at(t);
            q1 = fwd_at(t);
            if (q1 == t) begin
                q = p;
                q1 = p;
            end else begin
                put_fwd(q, p);
                put_back(q1, p);
            end
            wr_word(p, pack_word(0, sz + tsz, q1, q));
            put_back(t + tsz - 1, p);
            if (rover_at == t) rover_at = p;
        end else begin
            wr_word(p + sz - 1, pack_word(0, 0, 0, p));
            if (free_list_empty) begin
                wr_word(p, pack_word(0, sz, p, p));
                free_list_empty = 1'b0;
            end else begin
                q = back_at(rover_at);
                wr_word(p, pack_word(0, sz, rover_at, q));
                put_fwd(q, p);
                put_back(rover_at, p);
            end
            rover_at = p;
        end
    endfunction

    // Predicts one operation, records its result and queues the item for the driver.
    function automatic void issue_op(t_opcode op, int unsigned req, int unsigned addr);
        int unsigned head, t;
        bit ok;
        head = 0;
        ok = 1'b1;
        case (op)
            OP_INIT: begin
                t = total_cfg;
                if (t > STORE) t = STORE;
                if (t < 2) t = 2;
                wr_word(0, pack_word(0, t, 0, 0));
                wr_word(t - 1, pack_word(0, 0, 0, 0));
                rover_at = 0;
                free_list_empty = 1'b0;
                region_size = t;
                live_blocks.delete();
            end
            OP_ALLOC: begin
                ok = alloc_model(req, head);
                if (ok) live_blocks.push_back(head);
            end
            OP_FREE: free_model(addr);
            default: ;
        endcase
        want_addr_q.push_back(ok ? head[9:0] : '0);
        want_status_q.push_back(!ok);
        op_q.push_back(op);
        req_q.push_back(req[10:0]);
        addr_q.push_back(addr[9:0]);
    endfunction

    function automatic void free_live(int unsigned idx);
        int unsigned a;
        a = live_blocks[idx];
        live_blocks.delete(idx);
        issue_op(OP_FREE, $urandom, a);
    endfunction

    // True when a free of this address is dropped after looking at its head word alone.
    function automatic bit free_dropped(int unsigned a);
        if (a >= region_size || tag_at(a) == 0) return 1'b1;
        return (size_at(a) < 2 || a + size_at(a) > region_size);
    endfunction

    // Free of a written address that the block has to ignore.
    function automatic void free_written();
        int unsigned a, tries;
        tries = 0;
        a = $urandom_range(STORE - 1);
        while (!(heap_written[a] && free_dropped(a)) && tries < 64) begin
            a = $urandom_range(STORE - 1);
            tries++;
        end
        if (heap_written[a] && free_dropped(a)) issue_op(OP_FREE, $urandom, a);
    endfunction

    task automatic wait_idle();
        wait (op_q.size() == 0 && !i_in_valid && want_addr_q.size() == 0);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, int unsigned v);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v[10:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TOTAL) total_cfg = v & 32'h7FF;
        else slack_cfg = v & 32'h3FF;
    endtask

    task automatic random_phase(int unsigned count);
        int unsigned r, big;
        big = (region_size > 16) ? region_size / 6 : 4;
        issue_op(OP_INIT, $urandom, $urandom);
        for (int k = 0; k < count; k++) begin
            r = $urandom_range(99);
            if (r < 46) begin
                if ($urandom_range(19) == 0)
                    issue_op(OP_ALLOC, $urandom_range(2047), $urandom);
                else
                    issue_op(OP_ALLOC, $urandom_range(big, 1), $urandom);
            end else if (r < 86) begin
                if (live_blocks.size() > 0)
                    free_live($urandom_range(live_blocks.size() - 1));
                else
                    issue_op(OP_ALLOC, $urandom_range(big, 1), $urandom);
            end else if (r < 92) begin
                free_written();
            end else if (r < 97) begin
                issue_op(OP_NOP, $urandom, $urandom);
            end else begin
                issue_op(OP_INIT, $urandom, $urandom);
            end
            // Keep the generator only a little ahead of the driver.
            wait (op_q.size() < 8);
        end
    endtask

    initial begin
        for (int a = 0; a < STORE; a++) begin
            heap_mem[a] = '0;
            heap_written[a] = 1'b0;
        end
        rover_at = 0;
        region_size = 0;
        free_list_empty = 1'b1;
        total_cfg = 1024;
        slack_cfg = 8;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: operations on an unformatted store, then the field extremes.
        issue_op(OP_ALLOC, 5, 0);
        issue_op(OP_NOP, 2047, 1023);
        issue_op(OP_INIT, 0, 0);
        issue_op(OP_ALLOC, 0, 0);
        issue_op(OP_ALLOC, 1, 0);
        issue_op(OP_ALLOC, 2047, 0);
        issue_op(OP_ALLOC, 1024, 0);
        issue_op(OP_ALLOC, 100, 0);
        issue_op(OP_ALLOC, 2, 0);
        if (live_blocks.size() > 2) free_live(2);
        free_written();
        if (live_blocks.size() > 0) free_live(0);
        if (live_blocks.size() > 0) free_live(0);
        issue_op(OP_ALLOC, 1019, 0);
        issue_op(OP_ALLOC, 1, 0);
        wait_idle();

        // A small region with no slack, the whole store handed out at once, then the smallest region.
        write_reg(CFG_TOTAL, 4);
        write_reg(CFG_SLACK, 0);
        issue_op(OP_INIT, 0, 0);
        issue_op(OP_ALLOC, 2, 0);
        issue_op(OP_ALLOC, 2, 0);
        issue_op(OP_ALLOC, 1, 0);
        issue_op(OP_FREE, 0, 2);
        issue_op(OP_FREE, 0, 0);
        issue_op(OP_FREE, 0, 0);
        wait_idle();
        write_reg(CFG_TOTAL, 2047);
        write_reg(CFG_SLACK, 1023);
        issue_op(OP_INIT, 0, 0);
        issue_op(OP_ALLOC, 3, 0);
        issue_op(OP_ALLOC, 3, 0);
        issue_op(OP_FREE, 0, 0);
        wait_idle();
        write_reg(CFG_TOTAL, 1);
        issue_op(OP_INIT, 0, 0);
        issue_op(OP_ALLOC, 2, 0);
        issue_op(OP_FREE, 0, 0);
        wait_idle();

        // Random phases over several settings.
        write_reg(CFG_TOTAL, 1024);
        write_reg(CFG_SLACK, 8);
        random_phase(350);
        wait_idle();

        write_reg(CFG_TOTAL, $urandom_range(300, 40));
        write_reg(CFG_SLACK, 0);
        quiet = 1'b1;
        random_phase(250);
        wait_idle();
        quiet = 1'b0;

        write_reg(CFG_TOTAL, 1024);
        write_reg(CFG_SLACK, $urandom_range(4, 1));
        hold_request = 300;
        random_phase(350);
        wait_idle();

        write_reg(CFG_TOTAL, $urandom_range(1023, 500));
        write_reg(CFG_SLACK, $urandom_range(40, 10));
        random_phase(250);
        wait_idle();

        write_reg(CFG_TOTAL, 1024);
        write_reg(CFG_SLACK, 1023);
        random_phase(150);
        wait_idle();

        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Driver: presents queued items, idling now and then; a stalled item is held.
    always @(posedge i_clk) begin
        bit      done, offer;
        done = i_in_valid && !o_in_stall;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || done) begin
            offer = op_q.size() > 0 && (quiet || $urandom_range(99) >= 10);
            if (offer) begin
                i_opcode <= op_q.pop_front();
                i_request_words <= req_q.pop_front();
                i_block_address <= addr_q.pop_front();
            end
            i_in_valid <= offer;
        end
    end

    // Monitor: checks each result transfer and drives the output stall.
    always @(posedge i_clk) begin
        logic [ADDR_W-1:0] w_addr;
        logic              w_stat;
        bit                stall_next;
        if (o_out_valid && !i_out_stall && i_rst_n) begin
            if (want_addr_q.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                w_addr = want_addr_q.pop_front();
                w_stat = want_status_q.pop_front();
                if (o_result_address !== w_addr) begin
                    $error("result_address expected %0d actual %0d", w_addr, o_result_address);
                    errors++;
                end
                if (o_status !== w_stat) begin
                    $error("status expected %0d actual %0d", w_stat, o_status);
                    errors++;
                end
            end
        end
        if (hold_request > 0 && hold_left == 0 && op_q.size() > 4) begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            stall_next = 1'b1;
        end else begin
            stall_next = !quiet && $urandom_range(99) < 10;
        end
        i_out_stall <= i_rst_n ? stall_next : 1'b0;
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_MAX) begin
            $display("Mismatches found");
            $finish;
        end
    end

endmodule
